>>> src/tlmc_pkg.sv
// Package: shared types and constants for the touch lamp mode controller.
`timescale 1ns / 1ps

package tlmc_pkg;

    localparam int unsigned SENSE_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_LEVEL        = 2'd0,
        REG_OFF_LEVEL       = 2'd1,
        REG_SAMPLE_INTERVAL = 2'd2,
        REG_OFF_HOLD_TIME   = 2'd3
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_ON_LEVEL        = 16'd250;
    localparam logic [CFG_W-1:0] RST_OFF_LEVEL       = 16'd60;
    localparam logic [CFG_W-1:0] RST_SAMPLE_INTERVAL = 16'd200;
    localparam logic [CFG_W-1:0] RST_OFF_HOLD_TIME   = 16'd3000;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_TOUCH    = 2'd1,
        MODE_OFF      = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } t_edge;

    localparam logic [1:0] EFFECT_WARM = 2'd3;
    localparam logic [15:0] TIMER_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [CFG_W-1:0] on_level;
        logic [CFG_W-1:0] off_level;
        logic [CFG_W-1:0] sample_interval;
        logic [CFG_W-1:0] off_hold_time;
    } t_cfg;

    // Packed from the lowest bit: edge_event, lamp_mode, effect_index,
    // effect_changed, went_dark.
    typedef struct packed {
        logic       went_dark;
        logic       effect_changed;
        logic [1:0] effect_index;
        logic [1:0] lamp_mode;
        logic [1:0] edge_event;
    } t_result;

endpackage

>>> src/touch_lamp_mode_controller_unit.sv
// Top level: touch lamp mode controller with tick processing and output buffer.
`timescale 1ns / 1ps

// Takes one sensor tick per clock cycle while s_axis_tready is high and returns
// one result transaction per tick. All state (sample timer, level history,
// mode, effect, hold timer) is updated in the cycle a tick is accepted; the
// result is registered into an output register. A second skid register behind
// it lets one more tick in while downstream stalls, so s_axis_tready drops only
// when both hold results. Configuration writes take effect on the next cycle.

module touch_lamp_mode_controller_unit #(
    parameter int unsigned HISTORY_LEN = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlmc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] sense
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] edge_event, [3:2] lamp_mode, [5:4] effect_index,
    // [6] effect_changed, [7] went_dark
    output logic [7:0]                      m_axis_tdata
);

    localparam int unsigned RISE_LEN = HISTORY_LEN - HISTORY_LEN / 2;
    localparam logic [HISTORY_LEN-1:0] HIST_MASK = {HISTORY_LEN{1'b1}};
    localparam logic [HISTORY_LEN-1:0] RISE_PAT  = HIST_MASK >> (HISTORY_LEN - RISE_LEN);
    localparam logic [HISTORY_LEN-1:0] FALL_PAT  = HIST_MASK ^ RISE_PAT;

    tlmc_pkg::t_cfg w_cfg;

    tlmc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    logic [15:0]            r_sample_timer, n_sample_timer;
    logic [HISTORY_LEN-1:0] r_hist, n_hist;
    tlmc_pkg::t_mode        r_mode, n_mode;
    logic [1:0]             r_effect, n_effect;
    logic [15:0]            r_hold, n_hold;

    tlmc_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;

    logic        w_accept, w_pop;
    logic [15:0] w_elapsed;
    logic        w_lvl;
    tlmc_pkg::t_edge w_edge;
    logic        w_changed, w_dark;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = r_out_valid && m_axis_tready;

    always_comb begin
        w_elapsed = (r_sample_timer == tlmc_pkg::TIMER_MAX) ? tlmc_pkg::TIMER_MAX
                                                             : r_sample_timer + 16'd1;
        n_hist = r_hist;
        w_edge = tlmc_pkg::EDGE_NONE;
        w_lvl  = r_hist[0];
        if (s_axis_tdata > w_cfg.on_level) begin
            w_lvl = 1'b1;
        end else if (s_axis_tdata < w_cfg.off_level) begin
            w_lvl = 1'b0;
        end
        if (w_elapsed >= w_cfg.sample_interval) begin
            n_sample_timer = '0;
            n_hist = {r_hist[HISTORY_LEN-2:0], w_lvl};
            if (n_hist == RISE_PAT) begin
                w_edge = tlmc_pkg::EDGE_RISE;
            end else if (n_hist == FALL_PAT) begin
                w_edge = tlmc_pkg::EDGE_FALL;
            end
        end else begin
            n_sample_timer = w_elapsed;
        end

        n_hold    = (r_hold == tlmc_pkg::TIMER_MAX) ? r_hold : r_hold + 16'd1;
        n_mode    = r_mode;
        n_effect  = r_effect;
        w_changed = 1'b0;
        w_dark    = 1'b0;
        case (w_edge)
            tlmc_pkg::EDGE_RISE: begin
                n_effect  = (r_mode == tlmc_pkg::MODE_OFF) ? tlmc_pkg::EFFECT_WARM
                                                           : r_effect + 2'd1;
                w_changed = 1'b1;
                n_mode    = tlmc_pkg::MODE_TOUCH;
                n_hold    = '0;
            end
            tlmc_pkg::EDGE_FALL: begin
                if (r_mode != tlmc_pkg::MODE_OFF) begin
                    n_mode = tlmc_pkg::MODE_RELEASED;
                end
            end
            default: ;
        endcase
        if (n_mode == tlmc_pkg::MODE_TOUCH && n_hold > w_cfg.off_hold_time) begin
            n_mode = tlmc_pkg::MODE_OFF;
            w_dark = 1'b1;
        end

        n_result.edge_event     = w_edge;
        n_result.lamp_mode      = n_mode;
        n_result.effect_index   = n_effect;
        n_result.effect_changed = w_changed;
        n_result.went_dark      = w_dark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_timer <= '0;
            r_hist         <= '0;
            r_mode         <= tlmc_pkg::MODE_RELEASED;
            r_effect       <= tlmc_pkg::EFFECT_WARM;
            r_hold         <= '0;
        end else if (w_accept) begin
            r_sample_timer <= n_sample_timer;
            r_hist         <= n_hist;
            r_mode         <= n_mode;
            r_effect       <= n_effect;
            r_hold         <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_dark_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |->
            (m_axis_tdata[3:2] == tlmc_pkg::MODE_OFF))
        else $error("went_dark without lamp off");

    a_change_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |->
            (m_axis_tdata[1:0] == tlmc_pkg::EDGE_RISE &&
             m_axis_tdata[3:2] == tlmc_pkg::MODE_TOUCH))
        else $error("effect change without rising edge into touched mode");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == tlmc_pkg::MODE_OFF && w_edge == tlmc_pkg::EDGE_RISE) |=>
            (r_effect == tlmc_pkg::EFFECT_WARM))
        else $error("rising edge from off did not select warm default");

endmodule

>>> src/tlmc_cfg_regs.sv
// Configuration register file with write decode and reset values.
`timescale 1ns / 1ps

module tlmc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlmc_pkg::CFG_W-1:0]      i_cfg_wdata,
    output tlmc_pkg::t_cfg                  o_cfg
);

    tlmc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_level        <= tlmc_pkg::RST_ON_LEVEL;
            r_cfg.off_level       <= tlmc_pkg::RST_OFF_LEVEL;
            r_cfg.sample_interval <= tlmc_pkg::RST_SAMPLE_INTERVAL;
            r_cfg.off_hold_time   <= tlmc_pkg::RST_OFF_HOLD_TIME;
        end else if (i_cfg_we) begin
            case (tlmc_pkg::t_reg_idx'(i_cfg_index))
                tlmc_pkg::REG_ON_LEVEL:        r_cfg.on_level        <= i_cfg_wdata;
                tlmc_pkg::REG_OFF_LEVEL:       r_cfg.off_level       <= i_cfg_wdata;
                tlmc_pkg::REG_SAMPLE_INTERVAL: r_cfg.sample_interval <= i_cfg_wdata;
                tlmc_pkg::REG_OFF_HOLD_TIME:   r_cfg.off_hold_time   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
